>>> hw/rtl/psco_pkg.sv
// psco_pkg: shared constants and types for the shape overlap weight unit
// no dependencies
package psco_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned GUARD = 6;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_ORDER = 2'd1,
    ERR_WIDTH = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    PC_A = 2'd0,
    PC_B = 2'd1,
    PC_C = 2'd2,
    PC_D = 2'd3
  } piece_t;

  // result class decided by the classifier stage
  typedef enum logic [1:0] {
    RC_ZERO = 2'd0,
    RC_ONE  = 2'd1,
    RC_CUBE = 2'd2
  } rclass_t;

endpackage

>>> hw/rtl/psco_classify.sv
// psco_classify: edge tests and piece selection, two register stages
// depends on psco_pkg
module psco_classify #(
  parameter int unsigned POS_WIDTH = psco_pkg::POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [POS_WIDTH-1:0] position,
  input  logic [POS_WIDTH-2:0] half_width,
  input  logic [POS_WIDTH-1:0] edge_low,
  input  logic [POS_WIDTH-1:0] edge_high,
  output logic                 out_valid,
  output psco_pkg::rclass_t    rclass,
  output psco_pkg::piece_t     piece,
  output psco_pkg::err_t       err,
  output logic [POS_WIDTH:0]   num,
  output logic [POS_WIDTH-2:0] den
);
  localparam int unsigned EW = POS_WIDTH + 3;

  // stage 1: extended operands and comparison terms
  logic                 v1;
  logic signed [EW-1:0] x2, l2, r2, dd, x1, l1, r1, d1;
  logic [POS_WIDTH-2:0] dr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      x1  <= EW'($signed(position));
      l1  <= EW'($signed(edge_low));
      r1  <= EW'($signed(edge_high));
      d1  <= EW'({1'b0, half_width});
      dr1 <= half_width;
    end
  end

  always_comb begin
    x2 = x1 <<< 1;
    l2 = l1 <<< 1;
    r2 = r1 <<< 1;
    dd = d1;
  end

  logic              rc_n;
  psco_pkg::rclass_t rcl_n;
  psco_pkg::piece_t  pc_n;
  psco_pkg::err_t    er_n;
  logic signed [EW-1:0] n_n;

  always_comb begin
    rcl_n = psco_pkg::RC_CUBE;
    pc_n  = psco_pkg::PC_A;
    er_n  = psco_pkg::ERR_NONE;
    n_n   = '0;
    rc_n  = 1'b0;
    priority if (r1 < l1) begin
      rcl_n = psco_pkg::RC_ZERO; er_n = psco_pkg::ERR_ORDER;
    end else if (dd > r1 - l1) begin
      rcl_n = psco_pkg::RC_ZERO; er_n = psco_pkg::ERR_WIDTH;
    end else if (x1 < l1 - dd || x1 > r1 + dd) begin
      rcl_n = psco_pkg::RC_ZERO;
    end else if (dd == '0) begin
      rcl_n = psco_pkg::RC_ONE;
    end else if (x2 < l2 - dd) begin
      pc_n = psco_pkg::PC_A; n_n = x1 + dd - l1;
    end else if (x1 < l1) begin
      pc_n = psco_pkg::PC_B; n_n = l1 - x1;
    end else if (x2 > r2 + dd) begin
      pc_n = psco_pkg::PC_A; n_n = r1 + dd - x1;
    end else if (x1 > r1) begin
      pc_n = psco_pkg::PC_B; n_n = x1 - r1;
    end else if (x2 < l2 + dd) begin
      pc_n = psco_pkg::PC_C; n_n = x1 - l1;
    end else if (x1 < l1 + dd) begin
      pc_n = psco_pkg::PC_D; n_n = l1 + dd - x1;
    end else if (x2 > r2 - dd) begin
      pc_n = psco_pkg::PC_C; n_n = r1 - x1;
    end else if (x1 > r1 - dd) begin
      pc_n = psco_pkg::PC_D; n_n = x1 + dd - r1;
    end else begin
      rcl_n = psco_pkg::RC_ONE;
    end
    rc_n = (rcl_n == psco_pkg::RC_CUBE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      rclass <= rcl_n;
      piece  <= pc_n;
      err    <= er_n;
      // n never exceeds d on the cubic pieces
      num    <= rc_n ? (POS_WIDTH+1)'(n_n) : '0;
      den    <= dr1;
    end
  end
endmodule

>>> hw/rtl/psco_divide.sv
// psco_divide: pipelined restoring divider, one quotient bit per stage
// depends on psco_pkg
module psco_divide #(
  parameter int unsigned POS_WIDTH = psco_pkg::POS_WIDTH_DEF,
  parameter int unsigned GB        = psco_pkg::FRAC_BITS_DEF + psco_pkg::GUARD,
  parameter int unsigned TW        = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [TW-1:0]        in_tag,
  input  logic [POS_WIDTH:0]   num,
  input  logic [POS_WIDTH-2:0] den,
  output logic                 out_valid,
  output logic [TW-1:0]        out_tag,
  output logic [GB:0]          quot
);
  localparam int unsigned NS = GB + 1;
  localparam int unsigned RW = POS_WIDTH + 1;

  logic                 v  [NS+1];
  logic [TW-1:0]        tg [NS+1];
  logic [RW-1:0]        rm [NS+1];
  logic [POS_WIDTH-2:0] dv [NS+1];
  logic [GB:0]          qq [NS+1];

  always_comb begin
    v[0]  = in_valid;
    tg[0] = in_tag;
    rm[0] = num;
    dv[0] = den;
    qq[0] = '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [RW:0] sh;
    logic [RW:0] df;
    logic        ge;
    always_comb begin
      // first step compares unshifted remainder
      sh = (s == 0) ? {1'b0, rm[s]} : {rm[s], 1'b0};
      df = sh - (RW+1)'(dv[s]);
      ge = (sh >= (RW+1)'(dv[s]));
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        tg[s+1] <= tg[s];
        dv[s+1] <= dv[s];
        rm[s+1] <= ge ? RW'(df) : RW'(sh);
        qq[s+1] <= {qq[s][GB-1:0], ge};
      end
    end
  end

  assign out_valid = v[NS];
  assign out_tag   = tg[NS];
  assign quot      = qq[NS];
endmodule

>>> hw/rtl/psco_cubic.sv
// psco_cubic: cube of the ratio and piece assembly, three register stages
// depends on psco_pkg
module psco_cubic #(
  parameter int unsigned FRAC_BITS = psco_pkg::FRAC_BITS_DEF,
  parameter int unsigned TW        = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [TW-1:0]         in_tag,
  input  logic [FRAC_BITS+psco_pkg::GUARD:0] q,
  output logic                  out_valid,
  output logic [TW-1:0]         out_tag,
  output logic [FRAC_BITS:0]    weight
);
  localparam int unsigned GB = FRAC_BITS + psco_pkg::GUARD;
  localparam int unsigned QW = GB + 1;
  localparam int unsigned PW = 2 * QW;

  logic          va, vb, vc;
  logic [TW-1:0] ta, tb, tc;
  logic [QW-1:0] qa, qb, q2a, q3b, tcv;
  logic [PW-1:0] p1, p2;
  logic [QW+1:0] m3;
  logic [63:0]   m3p;

  always_comb begin
    p1 = PW'(q) * PW'(q);
    p2 = PW'(q2a) * PW'(qa);
    // multiply by two thirds through the reciprocal of three, exact while twice q3b is below 2^32
    m3p = 64'({q3b, 1'b0}) * 64'h0000_0000_AAAA_AAAB;
    m3  = (QW+2)'(m3p >> 33);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
    end else if (en) begin
      va <= in_valid; vb <= va; vc <= vb;
    end
    if (en) begin
      ta <= in_tag; tb <= ta; tc <= tb;
      qa  <= q;
      q2a <= QW'(p1 >> GB);
      qb  <= qa;
      q3b <= QW'(p2 >> GB);
      tcv <= QW'(m3);
    end
  end

  // final piece select is combinational on stage-c registers
  logic [QW-1:0] qc;
  always_ff @(posedge clk) begin
    if (en) begin
      qc <= qb;
    end
  end

  logic [QW+1:0] one_v, half_v, vv;
  always_comb begin
    one_v  = (QW+2)'(1) << GB;
    half_v = one_v >> 1;
    unique case (psco_pkg::piece_t'(tc[1:0]))
      psco_pkg::PC_A: vv = (QW+2)'(tcv);
      psco_pkg::PC_B: vv = (half_v + tcv >= qc) ? half_v + tcv - qc : '0;
      psco_pkg::PC_C: vv = (half_v + qc >= tcv) ? half_v + qc - tcv : '0;
      default:        vv = one_v - tcv;
    endcase
    if (vv > one_v) vv = one_v;
  end

  assign out_valid = vc;
  assign out_tag   = tc;
  assign weight    = (FRAC_BITS+1)'(vv >> psco_pkg::GUARD);
endmodule

>>> hw/rtl/particle_shape_cell_overlap_weight_unit.sv
// particle_shape_cell_overlap_weight_unit: a transaction passes the classifier stages,
// the bit-per-stage divider, the cubic stages and the output register in that order
// throughput one transaction per cycle; a stall freezes the whole pipeline
// an output register plus skid stage keeps tready independent of m_axis_tready
// rst is synchronous, active high, clears every valid bit
// depends on psco_pkg, psco_classify, psco_divide, psco_cubic
module particle_shape_cell_overlap_weight_unit #(
  parameter int unsigned POS_WIDTH = psco_pkg::POS_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = psco_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // position, half_width, edge_low, edge_high from bit 0 up, zero filled
  input  logic [((4*POS_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // weight, error_code from bit 0 up, zero filled
  output logic [((FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
  localparam int unsigned GB = FRAC_BITS + psco_pkg::GUARD;
  localparam int unsigned TW = 6;
  localparam int unsigned OW = ((FRAC_BITS + 3 + 7) / 8) * 8;

  // output stage and skid register
  logic          ov, sv;
  logic [OW-1:0] od, sd;
  logic          en;
  assign en            = !sv;
  assign s_axis_tready = en;

  logic                 cv;
  psco_pkg::rclass_t    rcl;
  psco_pkg::piece_t     pc;
  psco_pkg::err_t       er;
  logic [POS_WIDTH:0]   num;
  logic [POS_WIDTH-2:0] den;

  psco_classify #(.POS_WIDTH(POS_WIDTH)) u_cls (
    .clk, .rst, .en,
    .in_valid  (s_axis_tvalid && en),
    .position  (s_axis_tdata[POS_WIDTH-1:0]),
    .half_width(s_axis_tdata[2*POS_WIDTH-2:POS_WIDTH]),
    .edge_low  (s_axis_tdata[3*POS_WIDTH-2:2*POS_WIDTH-1]),
    .edge_high (s_axis_tdata[4*POS_WIDTH-2:3*POS_WIDTH-1]),
    .out_valid (cv), .rclass(rcl), .piece(pc), .err(er), .num, .den
  );

  // tag carries piece, class and error through the arithmetic
  logic [TW-1:0] tin, tdv, tcb;
  logic          dvv, cbv;
  logic [GB:0]   qt;
  logic [FRAC_BITS:0] wcub;
  assign tin = {er, rcl, pc};

  psco_divide #(.POS_WIDTH(POS_WIDTH), .GB(GB), .TW(TW)) u_div (
    .clk, .rst, .en, .in_valid(cv), .in_tag(tin), .num, .den,
    .out_valid(dvv), .out_tag(tdv), .quot(qt)
  );

  psco_cubic #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_cub (
    .clk, .rst, .en, .in_valid(dvv), .in_tag(tdv), .q(qt),
    .out_valid(cbv), .out_tag(tcb), .weight(wcub)
  );

  logic [FRAC_BITS:0] wsel;
  logic [OW-1:0]      rdat;
  always_comb begin
    unique case (psco_pkg::rclass_t'(tcb[3:2]))
      psco_pkg::RC_ONE:  wsel = (FRAC_BITS+1)'(1) << FRAC_BITS;
      psco_pkg::RC_CUBE: wsel = wcub;
      default:           wsel = '0;
    endcase
    rdat = OW'({tcb[5:4], wsel});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (en) begin
        if (!ov || m_axis_tready) begin
          ov <= cbv;
        end else if (cbv) begin
          sv <= 1'b1;
        end
      end else if (m_axis_tready) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end
    end
    if (en && (!ov || m_axis_tready)) begin
      od <= rdat;
    end else if (en && cbv) begin
      sd <= rdat;
    end else if (!en && m_axis_tready) begin
      od <= sd;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = od;

`ifndef SYNTHESIS
  a_skid_only_when_out_full: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov) else $error("skid holds data with output empty");
  a_err_zero_weight: assert property (@(posedge clk) disable iff (rst)
    ov && (od[FRAC_BITS+2:FRAC_BITS+1] != 2'd0) |-> (od[FRAC_BITS:0] == '0))
    else $error("error result with nonzero weight");
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    ov |-> (od[FRAC_BITS:0] <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
    else $error("weight above one");
`endif
endmodule
